// ----- rtl/hds_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hds_pkg - shared definitions for the 1-D heat diffusion stencil
// Sizes, reset values, command and register codes, controller/datapath links.
// ---------------------------------------------------------------------------
package hds_pkg;

  localparam int NUM_CELLS = 64;
  localparam int ADDR_W    = $clog2(NUM_CELLS);

  localparam int TEMP_W = 40;
  localparam int GAIN_W = 32;
  localparam int HEAT_W = 32;
  localparam int IDX_W  = 6;
  localparam int CMD_W  = 2;

  localparam int D_W   = TEMP_W + 3;
  localparam int M_W   = TEMP_W + 2;
  localparam int LO_W  = 32;
  localparam int MHI_W = M_W - LO_W;
  localparam int HP_W  = MHI_W + GAIN_W;
  localparam int Q_W   = HP_W + 1;
  localparam int V_W   = Q_W + 2;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;

  localparam logic [TEMP_W-1:0] TEMP_MAX  = '1;
  localparam logic [GAIN_W-1:0] GAIN_RST  = 32'd27089218;
  localparam logic [TEMP_W-1:0] INIT_RST  = 40'd5033164800;
  localparam logic [TEMP_W-1:0] BOUND_RST = 40'd4674132378;

  localparam logic [CMD_W-1:0] CMD_STEP   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELOAD = 2'd2;

  localparam logic [1:0] REG_GAIN  = 2'd0;
  localparam logic [1:0] REG_INIT  = 2'd1;
  localparam logic [1:0] REG_BOUND = 2'd2;

  typedef struct packed {
    logic              in_load;
    logic              sat_clr;
    logic              rd_en;
    logic              rd_step;
    logic [ADDR_W-1:0] rd_addr;
    logic              reload;
    logic              wr_first;
    logic              wr_last;
    logic              res_read;
    logic              res_step;
    logic              out_load;
  } hds_cmd_t;

  typedef struct packed {
    logic pipe_busy;
  } hds_sts_t;

endpackage
`default_nettype wire

// ----- rtl/hds_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hds_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module hds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hds_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hds_ctrl - command sequencer
// Accepts commands, sweeps the cell memory for a step, drives result handoff.
// ---------------------------------------------------------------------------
module hds_ctrl
  import hds_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [CMD_W-1:0] in_cmd_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  input  wire hds_sts_t         sts_i,
  output hds_cmd_t              cmd_o
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_STEP  = 4'd1;
  localparam logic [3:0] ST_DRAIN = 4'd2;
  localparam logic [3:0] ST_FIX0  = 4'd3;
  localparam logic [3:0] ST_FIXL  = 4'd4;
  localparam logic [3:0] ST_RD    = 4'd5;
  localparam logic [3:0] ST_RDW   = 4'd6;
  localparam logic [3:0] ST_RLD   = 4'd7;
  localparam logic [3:0] ST_PUT   = 4'd8;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(NUM_CELLS - 1);

  logic [3:0]        state_q, state_d;
  logic [ADDR_W-1:0] cnt_q, cnt_d;
  logic              oval_q, oval_d;
  logic              accept;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = oval_q;
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    oval_d  = oval_q;
    cmd_o   = '0;
    if (oval_q && out_ready_i) begin
      oval_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.in_load = 1'b1;
          case (in_cmd_i)
            CMD_STEP: begin
              cmd_o.sat_clr = 1'b1;
              cnt_d         = '0;
              state_d       = ST_STEP;
            end
            CMD_READ:   state_d = ST_RD;
            CMD_RELOAD: state_d = ST_RLD;
            default:    state_d = ST_IDLE;
          endcase
        end
      end
      ST_STEP: begin
        cmd_o.rd_en   = 1'b1;
        cmd_o.rd_step = 1'b1;
        cmd_o.rd_addr = cnt_q;
        cnt_d         = cnt_q + 1'b1;
        if (cnt_q == LAST_ADDR) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_FIX0;
        end
      end
      ST_FIX0: begin
        cmd_o.wr_first = 1'b1;
        state_d        = ST_FIXL;
      end
      ST_FIXL: begin
        cmd_o.wr_last  = 1'b1;
        cmd_o.res_step = 1'b1;
        state_d        = ST_PUT;
      end
      ST_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = ST_RDW;
      end
      ST_RDW: begin
        cmd_o.res_read = 1'b1;
        state_d        = ST_PUT;
      end
      ST_RLD: begin
        cmd_o.reload = 1'b1;
        state_d      = ST_PUT;
      end
      ST_PUT: begin
        if (!oval_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          oval_d         = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      oval_q  <= oval_d;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/hds_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hds_dp - stencil datapath
// Cell memory with valid bits, three-cell window, pipelined update, results.
// ---------------------------------------------------------------------------
module hds_dp
  import hds_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hds_cmd_t          cmd_i,
  output hds_sts_t               sts_o,
  input  wire logic [HEAT_W-1:0] heat_i,
  input  wire logic [IDX_W-1:0]  idx_i,
  input  wire logic [GAIN_W-1:0] gain_i,
  input  wire logic [TEMP_W-1:0] init_i,
  input  wire logic [TEMP_W-1:0] bound_i,
  output logic      [TEMP_W-1:0] temp_o,
  output logic                   sat_o
);

  logic [NUM_CELLS-1:0] valid_q;
  logic [TEMP_W-1:0]    base_q;
  logic                 sat_q;
  logic [HEAT_W-1:0]    heat_q;
  logic [IDX_W-1:0]     idx_q;

  logic [ADDR_W-1:0] raddr;
  logic [TEMP_W-1:0] ram_rdata;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [TEMP_W-1:0] wdata;

  logic              rdv_q, vbit_q;
  logic [ADDR_W-1:0] ra_q;
  logic [TEMP_W-1:0] s_data;
  logic [TEMP_W-1:0] w_prev_q, w_cur_q;

  logic              va_q, vb_q, vc_q, vd_q, ve_q, vf_q;
  logic [ADDR_W-1:0] ia_q, ib_q, ic_q, id_q, ie_q, if_q;
  logic [TEMP_W-1:0] cur_a_q, cur_b_q, cur_c_q, cur_d_q, cur_e_q;
  logic [D_W-1:0]    d_a_q;
  logic              neg_b_q, neg_c_q, neg_d_q, neg_e_q;
  logic [M_W-1:0]    m_b_q;
  logic [MHI_W-1:0]  mhi_c_q;
  logic [2*LO_W-1:0] lp_c_q;
  logic [HP_W-1:0]   hp_d_q;
  logic [LO_W-1:0]   lphi_d_q;
  logic              rnz_d_q;
  logic [Q_W-1:0]    q_e_q;
  logic [TEMP_W-1:0] wd_f_q, new1_q;
  logic              sat_f_q;

  logic [TEMP_W-1:0] res_temp_q;
  logic              res_sat_q;

  logic              a_fire, in_range;
  logic [D_W-1:0]    d_next;
  logic [M_W-1:0]    m_next;
  logic [V_W-1:0]    v_pos, q_ext, v_sum;
  logic [TEMP_W-1:0] v_clamp;
  logic              v_sat;

  assign raddr  = cmd_i.rd_step ? cmd_i.rd_addr : ADDR_W'(idx_q);
  assign s_data = vbit_q ? ram_rdata : base_q;
  assign a_fire = rdv_q && (ra_q >= ADDR_W'(2));
  assign in_range = 32'(idx_q) < 32'(NUM_CELLS);

  always_comb begin
    we    = 1'b0;
    waddr = if_q;
    wdata = wd_f_q;
    if (vf_q) begin
      we = 1'b1;
    end else if (cmd_i.wr_first) begin
      we    = 1'b1;
      waddr = '0;
      wdata = new1_q;
    end else if (cmd_i.wr_last) begin
      we    = 1'b1;
      waddr = ADDR_W'(NUM_CELLS - 1);
      wdata = bound_i;
    end
  end

  hds_ram #(
    .WIDTH (TEMP_W),
    .DEPTH (NUM_CELLS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    d_next = {{(D_W-TEMP_W){1'b0}}, s_data} + {{(D_W-TEMP_W){1'b0}}, w_prev_q}
           - {{(D_W-TEMP_W-1){1'b0}}, w_cur_q, 1'b0};
    m_next = M_W'(d_a_q[D_W-1] ? (~d_a_q + 1'b1) : d_a_q);
    v_pos  = {{(V_W-TEMP_W){1'b0}}, cur_e_q} + {{(V_W-HEAT_W){1'b0}}, heat_q};
    q_ext  = {{(V_W-Q_W){1'b0}}, q_e_q};
    v_sum  = neg_e_q ? (v_pos - q_ext) : (v_pos + q_ext);
    v_sat  = 1'b0;
    v_clamp = v_sum[TEMP_W-1:0];
    if (v_sum[V_W-1]) begin
      v_clamp = '0;
      v_sat   = 1'b1;
    end else if (|v_sum[V_W-2:TEMP_W]) begin
      v_clamp = TEMP_MAX;
      v_sat   = 1'b1;
    end
  end

  assign sts_o.pipe_busy = rdv_q | va_q | vb_q | vc_q | vd_q | ve_q | vf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      base_q  <= INIT_RST;
      sat_q   <= 1'b0;
      rdv_q   <= 1'b0;
      va_q    <= 1'b0;
      vb_q    <= 1'b0;
      vc_q    <= 1'b0;
      vd_q    <= 1'b0;
      ve_q    <= 1'b0;
      vf_q    <= 1'b0;
    end else begin
      if (cmd_i.reload) begin
        valid_q <= '0;
        base_q  <= init_i;
      end else if (we) begin
        valid_q[waddr] <= 1'b1;
      end
      if (cmd_i.sat_clr) begin
        sat_q <= 1'b0;
      end else if (vf_q && sat_f_q) begin
        sat_q <= 1'b1;
      end
      rdv_q <= cmd_i.rd_en && cmd_i.rd_step;
      va_q  <= a_fire;
      vb_q  <= va_q;
      vc_q  <= vb_q;
      vd_q  <= vc_q;
      ve_q  <= vd_q;
      vf_q  <= ve_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.in_load) begin
      heat_q <= heat_i;
      idx_q  <= idx_i;
    end
    if (cmd_i.rd_en) begin
      ra_q   <= raddr;
      vbit_q <= valid_q[raddr];
    end
    if (rdv_q) begin
      w_prev_q <= w_cur_q;
      w_cur_q  <= s_data;
    end
    ia_q    <= ra_q - 1'b1;
    cur_a_q <= w_cur_q;
    d_a_q   <= d_next;

    ib_q    <= ia_q;
    cur_b_q <= cur_a_q;
    neg_b_q <= d_a_q[D_W-1];
    m_b_q   <= m_next;

    ic_q    <= ib_q;
    cur_c_q <= cur_b_q;
    neg_c_q <= neg_b_q;
    mhi_c_q <= m_b_q[M_W-1:LO_W];
    lp_c_q  <= (2*LO_W)'(m_b_q[LO_W-1:0]) * (2*LO_W)'(gain_i);

    id_q     <= ic_q;
    cur_d_q  <= cur_c_q;
    neg_d_q  <= neg_c_q;
    hp_d_q   <= HP_W'(mhi_c_q) * HP_W'(gain_i);
    lphi_d_q <= lp_c_q[2*LO_W-1:LO_W];
    rnz_d_q  <= |lp_c_q[LO_W-1:0];

    ie_q    <= id_q;
    cur_e_q <= cur_d_q;
    neg_e_q <= neg_d_q;
    q_e_q   <= Q_W'(hp_d_q) + Q_W'(lphi_d_q) + Q_W'(neg_d_q && rnz_d_q);

    if_q    <= ie_q;
    wd_f_q  <= v_clamp;
    sat_f_q <= v_sat;

    if (vf_q && (if_q == ADDR_W'(1))) begin
      new1_q <= wd_f_q;
    end

    if (cmd_i.res_read) begin
      res_temp_q <= in_range ? s_data : '0;
      res_sat_q  <= 1'b0;
    end else if (cmd_i.res_step) begin
      res_temp_q <= new1_q;
      res_sat_q  <= sat_q;
    end else if (cmd_i.reload) begin
      res_temp_q <= init_i;
      res_sat_q  <= 1'b0;
    end
    if (cmd_i.out_load) begin
      temp_o <= res_temp_q;
      sat_o  <= res_sat_q;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/heat_diffusion_stencil_1d_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// heat_diffusion_stencil_1d_top - explicit 1-D heat diffusion over a cell row
//
// Commands arrive on the s_axis channel: tuser carries the command (step,
// read one cell, reload), tdata the heat increment and the cell index.
// Each step, read or reload yields one result on m_axis: tdata holds a
// temperature in Q16.24, tuser the saturation flag of a step.
// Gain, initial temperature and boundary temperature sit behind the APB
// port at byte addresses 0, 8 and 16; write them only while idle.
// A step sweeps the cell memory one cell per cycle through a six-stage
// update pipeline, waits for it to drain and then rewrites both end
// cells before its result is loaded; a read fetches one cell, a reload
// returns every cell to the initial temperature. One command is in flight
// at a time; the next command transfer can be taken at the edge of the
// result transfer or while that result still waits on m_axis, and the
// block holds the following result when the receiver stalls.
// Reset restores register defaults and marks every cell as holding the
// default initial temperature at once; no clearing pass is needed.
// ---------------------------------------------------------------------------
module heat_diffusion_stencil_1d_top
  import hds_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire logic [39:0]       s_axis_tdata,  // [31:0] heat_increment, [37:32] cell_index
  input  wire logic [CMD_W-1:0]  s_axis_tuser,  // [1:0] command
  output logic                   m_axis_tvalid,
  input  wire logic              m_axis_tready,
  output logic      [TEMP_W-1:0] m_axis_tdata,  // [39:0] temperature
  output logic                   m_axis_tuser,  // [0] saturated
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic      [CFG_DW-1:0] prdata,
  output logic                   pready
);

  logic [GAIN_W-1:0] gain_q;
  logic [TEMP_W-1:0] init_q;
  logic [TEMP_W-1:0] bound_q;
  logic              cfg_wr;
  hds_cmd_t          cmd;
  hds_sts_t          sts;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q  <= GAIN_RST;
      init_q  <= INIT_RST;
      bound_q <= BOUND_RST;
    end else if (cfg_wr) begin
      case (paddr[4:3])
        REG_GAIN:  gain_q  <= pwdata[GAIN_W-1:0];
        REG_INIT:  init_q  <= pwdata[TEMP_W-1:0];
        REG_BOUND: bound_q <= pwdata[TEMP_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_GAIN:  prdata = {{(CFG_DW-GAIN_W){1'b0}}, gain_q};
      REG_INIT:  prdata = {{(CFG_DW-TEMP_W){1'b0}}, init_q};
      REG_BOUND: prdata = {{(CFG_DW-TEMP_W){1'b0}}, bound_q};
      default:   prdata = '0;
    endcase
  end

  hds_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_cmd_i    (s_axis_tuser),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  hds_dp u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cmd),
    .sts_o   (sts),
    .heat_i  (s_axis_tdata[HEAT_W-1:0]),
    .idx_i   (s_axis_tdata[HEAT_W+IDX_W-1:HEAT_W]),
    .gain_i  (gain_q),
    .init_i  (init_q),
    .bound_i (bound_q),
    .temp_o  (m_axis_tdata),
    .sat_o   (m_axis_tuser)
  );

endmodule
`default_nettype wire

// ----- rtl/hds_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// hds_checker - port-level checks for the heat diffusion stencil
// Watches the top-level ports only; attached by bind.
// ---------------------------------------------------------------------------
module hds_checker
  import hds_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid,
  input wire logic              s_axis_tready,
  input wire logic [CMD_W-1:0]  s_axis_tuser,
  input wire logic              m_axis_tvalid,
  input wire logic              m_axis_tready,
  input wire logic [TEMP_W-1:0] m_axis_tdata,
  input wire logic              m_axis_tuser
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("result changed while stalled");

  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready &&
     (s_axis_tuser == CMD_STEP || s_axis_tuser == CMD_READ ||
      s_axis_tuser == CMD_RELOAD)) |=> !s_axis_tready)
    else $error("command transfer did not start work");

  a_result_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a command in flight");

  a_read_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && s_axis_tuser == CMD_READ && !m_axis_tvalid) |->
      ##4 (m_axis_tvalid && !m_axis_tuser))
    else $error("read result late or flagged");

endmodule

bind heat_diffusion_stencil_1d_top hds_checker u_hds_checker (.*);
`default_nettype wire

// ----- dv/heat_diffusion_stencil_1d_top_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// heat_diffusion_stencil_1d_top_tb - self-checking bench for the heat stencil
// Drives step, read, reload and unused commands over the input stream and
// writes the three APB registers between phases. A cycle-free predictor of
// the cell row computes each expected temperature and clamp flag at transfer
// time, and every result transfer is compared against the oldest prediction.
// Runs directed reset, clamping and register-extreme tests, then random
// traffic under three sender/receiver stall mixes.
// ---------------------------------------------------------------------------
module heat_diffusion_stencil_1d_top_tb;
  import hds_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int SETTLE_CYCLES = 100;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic              sat;
  } temp_result_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [39:0]       s_axis_tdata = '0;  // [31:0] heat_increment, [37:32] cell_index
  logic [CMD_W-1:0]  s_axis_tuser = '0;  // [1:0] command
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TEMP_W-1:0] m_axis_tdata;       // [39:0] temperature
  logic              m_axis_tuser;       // [0] saturated
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [CFG_AW-1:0] paddr = '0;
  logic [CFG_DW-1:0] pwdata = '0;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  // predictor state
  logic [TEMP_W-1:0] cell_row [NUM_CELLS];
  logic [GAIN_W-1:0] gain_q;
  logic [TEMP_W-1:0] init_q;
  logic [TEMP_W-1:0] bound_q;
  temp_result_t      pending_temps [$];
  temp_result_t      oldest;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          mismatch_count = 0;

  heat_diffusion_stencil_1d_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    m_axis_tready = ($urandom_range(99) >= recv_idle_pct);
  end

  function automatic longint gain_floor(logic [GAIN_W-1:0] g, longint dlt);
    logic [63:0] mag;
    logic [79:0] prod;
    longint      q;
    mag  = (dlt < 0) ? -dlt : dlt;
    prod = {16'b0, mag} * {48'b0, g};
    q    = longint'({16'b0, prod[79:32]});
    if (dlt < 0) begin
      if (prod[31:0] != '0) q = q + 1;
      q = -q;
    end
    return q;
  endfunction

  function automatic void reload_row();
    for (int k = 0; k < NUM_CELLS; k++) cell_row[k] = init_q;
  endfunction

  function automatic void predict_command(logic [CMD_W-1:0] cmd, logic [HEAT_W-1:0] heat,
                                          logic [IDX_W-1:0] idx);
    temp_result_t res;
    longint       prev, cur, nxt, dlt, v;
    res = '0;
    case (cmd)
      CMD_STEP: begin
        prev = longint'({24'b0, cell_row[0]});
        for (int i = 1; i < NUM_CELLS - 1; i++) begin
          cur = longint'({24'b0, cell_row[i]});
          nxt = longint'({24'b0, cell_row[i+1]});
          dlt = nxt - 2 * cur + prev;
          v   = cur + gain_floor(gain_q, dlt) + longint'({32'b0, heat});
          if (v < 0) begin
            v = 0;
            res.sat = 1'b1;
          end else if (v > longint'({24'b0, TEMP_MAX})) begin
            v = longint'({24'b0, TEMP_MAX});
            res.sat = 1'b1;
          end
          cell_row[i] = v[TEMP_W-1:0];
          prev = cur;
        end
        cell_row[0] = cell_row[1];
        cell_row[NUM_CELLS-1] = bound_q;
        res.temp = cell_row[0];
        pending_temps.push_back(res);
      end
      CMD_READ: begin
        res.temp = (int'(idx) < NUM_CELLS) ? cell_row[idx] : '0;
        pending_temps.push_back(res);
      end
      CMD_RELOAD: begin
        reload_row();
        res.temp = cell_row[0];
        pending_temps.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_temps.size() == 0) begin
        $display("%0t: result with none pending: temperature=%h saturated=%b",
                 $time, m_axis_tdata, m_axis_tuser);
        mismatch_count++;
      end else begin
        oldest = pending_temps.pop_front();
        if (m_axis_tdata !== oldest.temp) begin
          $display("%0t: temperature mismatch: expected %h actual %h",
                   $time, oldest.temp, m_axis_tdata);
          mismatch_count++;
        end
        if (m_axis_tuser !== oldest.sat) begin
          $display("%0t: saturated mismatch: expected %b actual %b",
                   $time, oldest.sat, m_axis_tuser);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_command(input logic [CMD_W-1:0] cmd, input logic [HEAT_W-1:0] heat,
                              input logic [IDX_W-1:0] idx);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = {2'b00, idx, heat};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_command(cmd, heat, idx);
    @(negedge clk_i);
  endtask

  task automatic wait_idle();
    s_axis_tvalid = 1'b0;
    while (pending_temps.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] reg_id, input logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] expected_rd;
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {reg_id, 3'b000};
    pwdata  = value;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (reg_id)
      REG_GAIN: begin
        gain_q      = value[GAIN_W-1:0];
        expected_rd = {{(CFG_DW-GAIN_W){1'b0}}, value[GAIN_W-1:0]};
      end
      REG_INIT: begin
        init_q      = value[TEMP_W-1:0];
        expected_rd = {{(CFG_DW-TEMP_W){1'b0}}, value[TEMP_W-1:0]};
      end
      REG_BOUND: begin
        bound_q     = value[TEMP_W-1:0];
        expected_rd = {{(CFG_DW-TEMP_W){1'b0}}, value[TEMP_W-1:0]};
      end
      default: expected_rd = '0;
    endcase
    @(negedge clk_i);
    if (prdata !== expected_rd) begin
      $display("%0t: register read mismatch: expected %h actual %h",
               $time, expected_rd, prdata);
      mismatch_count++;
    end
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  function automatic logic [TEMP_W-1:0] rand_temp();
    case ($urandom_range(5))
      0:       return '0;
      1:       return TEMP_MAX;
      2:       return {8'($urandom_range(255)), 32'($urandom())};
      default: return {8'($urandom_range(255, 64)), 32'($urandom())};
    endcase
  endfunction

  function automatic logic [GAIN_W-1:0] rand_gain();
    case ($urandom_range(7))
      0:       return '0;
      1:       return '1;
      2:       return $urandom();
      default: return $urandom_range(32'h3FFF_FFFF);
    endcase
  endfunction

  function automatic logic [HEAT_W-1:0] rand_heat();
    case ($urandom_range(4))
      0:       return $urandom_range(1 << 16);
      1:       return $urandom();
      2:       return $urandom_range(1) ? '1 : '0;
      default: return $urandom_range(1 << 24);
    endcase
  endfunction

  task automatic test_reset_values();
    send_command(CMD_READ, '0, 6'd0);
    send_command(CMD_READ, '0, 6'd63);
    send_command(CMD_READ, 32'hA5A5_5A5A, 6'd37);
    send_command(CMD_STEP, '0, 6'd0);
    send_command(CMD_STEP, '1, 6'd63);
    send_command(CMD_READ, '0, 6'd62);
    send_command(CMD_READ, '0, 6'd63);
    send_command(CMD_UNUSED, '1, 6'd21);
    send_command(CMD_RELOAD, 32'h1234_5678, 6'd42);
    send_command(CMD_READ, '0, 6'd1);
    wait_idle();
  endtask

  task automatic test_clamping();
    write_reg(REG_GAIN, {32'b0, {GAIN_W{1'b1}}});
    write_reg(REG_INIT, {24'b0, TEMP_MAX});
    write_reg(REG_BOUND, '0);
    send_command(CMD_RELOAD, '0, 6'd0);
    send_command(CMD_STEP, '1, 6'd0);
    repeat (5) send_command(CMD_STEP, '0, 6'd0);
    send_command(CMD_READ, '0, 6'd61);
    send_command(CMD_READ, '0, 6'd62);
    wait_idle();
  endtask

  task automatic test_register_extremes();
    write_reg(REG_INIT, '0);
    write_reg(REG_GAIN, '0);
    write_reg(REG_BOUND, {24'b0, TEMP_MAX});
    send_command(CMD_RELOAD, '0, 6'd0);
    send_command(CMD_STEP, $urandom(), 6'd0);
    send_command(CMD_READ, '0, 6'd63);
    send_command(CMD_READ, '0, 6'd42);
    wait_idle();
  endtask

  task automatic test_random_traffic(input int unsigned snd_pct, input int unsigned rcv_pct,
                                     input int chunks, input int per_chunk);
    logic [CMD_W-1:0] cmd;
    int unsigned      pick;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    for (int c = 0; c < chunks; c++) begin
      write_reg(REG_GAIN, {32'b0, rand_gain()});
      write_reg(REG_INIT, {24'b0, rand_temp()});
      write_reg(REG_BOUND, {24'b0, rand_temp()});
      if ($urandom_range(1)) send_command(CMD_RELOAD, rand_heat(), 6'($urandom_range(63)));
      for (int n = 0; n < per_chunk; n++) begin
        pick = $urandom_range(99);
        if (pick < 45)      cmd = CMD_STEP;
        else if (pick < 85) cmd = CMD_READ;
        else if (pick < 95) cmd = CMD_RELOAD;
        else                cmd = CMD_UNUSED;
        send_command(cmd, rand_heat(), 6'($urandom_range(63)));
      end
      wait_idle();
    end
  endtask

  initial begin
    gain_q  = GAIN_RST;
    init_q  = INIT_RST;
    bound_q = BOUND_RST;
    reload_row();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    send_idle_pct = 28;
    recv_idle_pct = 57;
    test_reset_values();
    test_clamping();
    test_register_extremes();
    test_random_traffic(28, 57, 4, 70);
    test_random_traffic(57, 28, 4, 70);
    test_random_traffic(0, 0, 4, 70);
    wait_idle();
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
